[sv/wbm_pkg.sv]
// Shared types and codes for the watchpoint and breakpoint matcher.
// Used by the datapath, the controller, the top level and the checker.
package wbm_pkg;

  // Request codes carried in req_type.
  localparam logic [2:0] REQ_ADD_BP = 3'd0;
  localparam logic [2:0] REQ_ADD_WP = 3'd1;
  localparam logic [2:0] REQ_REMOVE = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;
  localparam logic [2:0] REQ_WRITE  = 3'd5;
  localparam logic [2:0] REQ_INSTR  = 3'd6;

  // Watchpoint kinds.
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_RW     = 2'd2;
  localparam logic [1:0] KIND_CHANGE = 2'd3;

  // Hit sources.
  localparam logic [1:0] SRC_READ_WATCH  = 2'd0;
  localparam logic [1:0] SRC_WRITE_WATCH = 2'd1;
  localparam logic [1:0] SRC_BREAKPOINT  = 2'd2;

  // One request word.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] address;
    logic [15:0] range_end;
    logic [1:0]  watch_kind;
    logic        cond_enable;
    logic [7:0]  cond_value;
    logic [7:0]  old_value;
    logic [7:0]  new_value;
    logic [15:0] point_id;
    logic        debugger_access;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [15:0] assigned_id;
    logic        table_full;
    logic        hit;
    logic [15:0] hit_id;
    logic [1:0]  hit_source;
    logic [1:0]  hit_kind;
    logic [15:0] hit_address;
    logic [7:0]  hit_old;
    logic [7:0]  hit_new;
  } out_word_t;

  // Stored table entries.
  typedef struct packed {
    logic [15:0] address;
    logic [15:0] ident;
  } bp_entry_t;

  typedef struct packed {
    logic [15:0] low;
    logic [15:0] high;
    logic [1:0]  kind;
    logic        cond_on;
    logic [7:0]  cond_value;
    logic [15:0] ident;
  } wp_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // latch the accepted request, clear the result
    logic exec;  // work done in the execute state: add, clear
    logic scan;  // walk a table one entry per cycle
    logic emit;  // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_scan;
    logic scan_done;
  } ctrl_sts_t;

endpackage

[sv/wbm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/wbm_ctrl.sv]
// Controller state machine of the matcher: sequences load, execute, table scan and result.
// Depends on wbm_pkg for the command and status structs.
module wbm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  wbm_pkg::ctrl_sts_t sts_i,
  output wbm_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = sts_i.is_scan ? ST_SCAN : ST_DONE;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The output word stays valid until it is taken.
  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/wbm_datapath.sv]
// Datapath of the matcher: table memories, counts, id counter, scan and match logic.
// Depends on wbm_pkg and wbm_ram.
module wbm_datapath #(
  parameter int BP_SLOTS = 16,
  parameter int WP_SLOTS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wbm_pkg::in_word_t  in_data_i,
  input  wbm_pkg::ctrl_cmd_t cmd_i,
  output wbm_pkg::ctrl_sts_t sts_o,
  output wbm_pkg::out_word_t out_data_o
);

  localparam int BIW = (BP_SLOTS > 1) ? $clog2(BP_SLOTS) : 1;
  localparam int WIW = (WP_SLOTS > 1) ? $clog2(WP_SLOTS) : 1;
  localparam int BCW = $clog2(BP_SLOTS + 1);
  localparam int WCW = $clog2(WP_SLOTS + 1);
  localparam int SCW = (BCW > WCW) ? BCW : WCW;

  wbm_pkg::in_word_t  req_q;
  wbm_pkg::out_word_t res_q, res_d;
  wbm_pkg::out_word_t out_q;

  logic [BCW-1:0] bp_cnt_q, bp_cnt_d;
  logic [WCW-1:0] wp_cnt_q, wp_cnt_d;
  logic [15:0]    next_id_q, next_id_d;
  logic [SCW-1:0] ridx_q, ridx_d;
  logic [SCW-1:0] widx_q, widx_d;
  logic           pvalid_q, pvalid_d;
  logic           pass_wp_q, pass_wp_d;

  logic                 bp_we, wp_we;
  logic [BIW-1:0]       bp_waddr;
  logic [WIW-1:0]       wp_waddr;
  wbm_pkg::bp_entry_t   bp_wdata, bp_rdata;
  wbm_pkg::wp_entry_t   wp_wdata, wp_rdata;
  logic [$bits(wbm_pkg::bp_entry_t)-1:0] bp_rvec;
  logic [$bits(wbm_pkg::wp_entry_t)-1:0] wp_rvec;

  logic           is_rdwr, is_remove, sel_wp;
  logic [SCW-1:0] cnt_sel;
  logic           issue, pass_end;
  logic           bp_full, wp_full;
  logic           covered, kind_ok, cond_ok, bp_match, found;

  // Table memories, read at the scan index.
  wbm_ram #(.WIDTH($bits(wbm_pkg::bp_entry_t)), .DEPTH(BP_SLOTS)) u_bp_ram (
    .clk_i   (clk_i),
    .we_i    (bp_we),
    .waddr_i (bp_waddr),
    .wdata_i (bp_wdata),
    .raddr_i (ridx_q[BIW-1:0]),
    .rdata_o (bp_rvec)
  );

  wbm_ram #(.WIDTH($bits(wbm_pkg::wp_entry_t)), .DEPTH(WP_SLOTS)) u_wp_ram (
    .clk_i   (clk_i),
    .we_i    (wp_we),
    .waddr_i (wp_waddr),
    .wdata_i (wp_wdata),
    .raddr_i (ridx_q[WIW-1:0]),
    .rdata_o (wp_rvec)
  );

  assign bp_rdata = bp_rvec;
  assign wp_rdata = wp_rvec;

  // Request decode and scan bookkeeping.
  assign is_rdwr   = (req_q.req_type == wbm_pkg::REQ_READ) ||
                     (req_q.req_type == wbm_pkg::REQ_WRITE);
  assign is_remove = (req_q.req_type == wbm_pkg::REQ_REMOVE);
  assign sel_wp    = is_rdwr || pass_wp_q;
  assign cnt_sel   = sel_wp ? SCW'(wp_cnt_q) : SCW'(bp_cnt_q);
  assign issue     = cmd_i.scan && (ridx_q < cnt_sel);
  assign pass_end  = (ridx_q >= cnt_sel) && !pvalid_q;
  assign bp_full   = (bp_cnt_q == BCW'(BP_SLOTS));
  assign wp_full   = (wp_cnt_q == WCW'(WP_SLOTS));

  // Match tests on the entry that came back from memory.
  assign covered  = (wp_rdata.low <= req_q.address) && (req_q.address <= wp_rdata.high);
  assign cond_ok  = !wp_rdata.cond_on || (req_q.new_value == wp_rdata.cond_value);
  assign bp_match = (bp_rdata.address == req_q.address);
  always_comb begin
    if (req_q.req_type == wbm_pkg::REQ_READ) begin
      kind_ok = (wp_rdata.kind == wbm_pkg::KIND_READ) || (wp_rdata.kind == wbm_pkg::KIND_RW);
    end else begin
      kind_ok = (wp_rdata.kind == wbm_pkg::KIND_WRITE) || (wp_rdata.kind == wbm_pkg::KIND_RW) ||
                ((wp_rdata.kind == wbm_pkg::KIND_CHANGE) &&
                 (req_q.old_value != req_q.new_value));
    end
  end

  // A search stops at the first covering watchpoint or the first equal breakpoint.
  assign found = cmd_i.scan && pvalid_q &&
                 ((is_rdwr && covered) ||
                  ((req_q.req_type == wbm_pkg::REQ_INSTR) && bp_match));

  assign sts_o.is_scan   = is_remove || (req_q.req_type == wbm_pkg::REQ_INSTR) ||
                           (is_rdwr && !req_q.debugger_access);
  assign sts_o.scan_done = found || (cmd_i.scan && pass_end && (!is_remove || pass_wp_q));

  // Next-state logic for counts, indexes, memory writes and the result.
  always_comb begin
    res_d     = res_q;
    bp_cnt_d  = bp_cnt_q;
    wp_cnt_d  = wp_cnt_q;
    next_id_d = next_id_q;
    ridx_d    = ridx_q;
    widx_d    = widx_q;
    pvalid_d  = pvalid_q;
    pass_wp_d = pass_wp_q;
    bp_we     = 1'b0;
    wp_we     = 1'b0;
    bp_waddr  = widx_q[BIW-1:0];
    wp_waddr  = widx_q[WIW-1:0];
    bp_wdata  = bp_rdata;
    wp_wdata  = wp_rdata;

    if (cmd_i.load) begin
      res_d     = '0;
      ridx_d    = '0;
      widx_d    = '0;
      pvalid_d  = 1'b0;
      pass_wp_d = 1'b0;
    end

    // Requests handled in the execute state.
    if (cmd_i.exec) begin
      unique case (req_q.req_type)
        wbm_pkg::REQ_ADD_BP: begin
          if (bp_full) begin
            res_d.table_full = 1'b1;
          end else begin
            bp_we             = 1'b1;
            bp_waddr          = bp_cnt_q[BIW-1:0];
            bp_wdata.address  = req_q.address;
            bp_wdata.ident    = next_id_q;
            bp_cnt_d          = bp_cnt_q + BCW'(1);
            res_d.assigned_id = next_id_q;
            next_id_d         = next_id_q + 16'd1;
          end
        end
        wbm_pkg::REQ_ADD_WP: begin
          if (wp_full) begin
            res_d.table_full = 1'b1;
          end else begin
            wp_we               = 1'b1;
            wp_waddr            = wp_cnt_q[WIW-1:0];
            wp_wdata.low        = req_q.address;
            wp_wdata.high       = req_q.range_end;
            wp_wdata.kind       = req_q.watch_kind;
            wp_wdata.cond_on    = req_q.cond_enable;
            wp_wdata.cond_value = req_q.cond_value;
            wp_wdata.ident      = next_id_q;
            wp_cnt_d            = wp_cnt_q + WCW'(1);
            res_d.assigned_id   = next_id_q;
            next_id_d           = next_id_q + 16'd1;
          end
        end
        wbm_pkg::REQ_CLEAR: begin
          bp_cnt_d = '0;
          wp_cnt_d = '0;
        end
        default: begin
        end
      endcase
    end

    // Table walk: issue one read per cycle, judge the entry read the cycle before.
    if (cmd_i.scan) begin
      pvalid_d = issue;
      if (issue) begin
        ridx_d = ridx_q + SCW'(1);
      end
      if (pvalid_q) begin
        if (is_remove) begin
          // Compaction: survivors are copied down to the write index.
          if (!pass_wp_q && (bp_rdata.ident != req_q.point_id)) begin
            bp_we  = 1'b1;
            widx_d = widx_q + SCW'(1);
          end
          if (pass_wp_q && (wp_rdata.ident != req_q.point_id)) begin
            wp_we  = 1'b1;
            widx_d = widx_q + SCW'(1);
          end
        end else if (is_rdwr) begin
          if (covered && kind_ok && cond_ok) begin
            res_d.hit         = 1'b1;
            res_d.hit_id      = wp_rdata.ident;
            res_d.hit_source  = (req_q.req_type == wbm_pkg::REQ_READ) ?
                                wbm_pkg::SRC_READ_WATCH : wbm_pkg::SRC_WRITE_WATCH;
            res_d.hit_kind    = wp_rdata.kind;
            res_d.hit_address = req_q.address;
            res_d.hit_old     = (req_q.req_type == wbm_pkg::REQ_READ) ?
                                req_q.new_value : req_q.old_value;
            res_d.hit_new     = req_q.new_value;
          end
        end else if (bp_match) begin
          res_d.hit         = 1'b1;
          res_d.hit_id      = bp_rdata.ident;
          res_d.hit_source  = wbm_pkg::SRC_BREAKPOINT;
          res_d.hit_address = req_q.address;
        end
      end
      // End of a remove pass: commit the new count, and after the breakpoint pass move to the watch table.
      if (is_remove && pass_end) begin
        if (!pass_wp_q) begin
          bp_cnt_d  = widx_q[BCW-1:0];
          pass_wp_d = 1'b1;
          ridx_d    = '0;
          widx_d    = '0;
          pvalid_d  = 1'b0;
        end else begin
          wp_cnt_d = widx_q[WCW-1:0];
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bp_cnt_q  <= '0;
      wp_cnt_q  <= '0;
      next_id_q <= '0;
      ridx_q    <= '0;
      widx_q    <= '0;
      pvalid_q  <= 1'b0;
      pass_wp_q <= 1'b0;
    end else begin
      bp_cnt_q  <= bp_cnt_d;
      wp_cnt_q  <= wp_cnt_d;
      next_id_q <= next_id_d;
      ridx_q    <= ridx_d;
      widx_q    <= widx_d;
      pvalid_q  <= pvalid_d;
      pass_wp_q <= pass_wp_d;
    end
  end

  // Payload registers: request, working result and output word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= in_data_i;
    end
    res_q <= res_d;
    if (cmd_i.emit) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

endmodule

[sv/watchpoint_breakpoint_matcher_top.sv]
// Debug trigger unit that keeps a breakpoint table and a watchpoint table and reports hits.
// Timing: the block takes one word at a time. The first edge at which a word's result word
// can be taken is also the first edge at which the next word can be taken; a stalled result
// side adds to the wait. Add, clear, an unused code, and a read or write flagged as the
// debugger's own pass through the execute state and walk no table. A read or write walks
// the watchpoint table and stops at the first covering watchpoint, whether it hits or not,
// or reads every watchpoint held if none covers. An instruction check walks the breakpoints
// the same way, stopping at the first equal address. A remove walks the breakpoint table and
// then the watchpoint table, compacting each. The table walk does one memory read per cycle
// on the RAM of the table being walked. The finished word sits in an output register, so a
// new word is taken while it waits.
// Depends on wbm_pkg, wbm_ctrl and wbm_datapath.
module watchpoint_breakpoint_matcher_top #(
  parameter int BP_SLOTS = 16,
  parameter int WP_SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wbm_pkg::in_word_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wbm_pkg::out_word_t out_data_o
);

  wbm_pkg::ctrl_cmd_t cmd;
  wbm_pkg::ctrl_sts_t sts;

  // Sequencer.
  wbm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Tables and match logic.
  wbm_datapath #(
    .BP_SLOTS (BP_SLOTS),
    .WP_SLOTS (WP_SLOTS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

[sv/wbm_checker.sv]
// Port-level checks for the matcher, attached to the top level by a bind statement.
// Depends on wbm_pkg and watchpoint_breakpoint_matcher_top.
module wbm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input wbm_pkg::out_word_t out_data_o
);

  // One word at a time: in the cycle after acceptance the input side is closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted on two consecutive cycles");

  // A refused add gives no id and no hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.table_full |->
      (out_data_o.assigned_id == 16'd0) && !out_data_o.hit)
    else $error("table full word carries an id or a hit");

  // A word without a hit has its hit id, address, old and new values and source at zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.hit |->
      (out_data_o.hit_id == 16'd0) && (out_data_o.hit_address == 16'd0) &&
      (out_data_o.hit_old == 8'd0) && (out_data_o.hit_new == 8'd0) &&
      (out_data_o.hit_source == wbm_pkg::SRC_READ_WATCH))
    else $error("hit fields set on a word without a hit");

  // A waiting result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word dropped or changed while stalled");

endmodule

bind watchpoint_breakpoint_matcher_top wbm_checker u_wbm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
